FILE: rtl/integer_partition_stepper_core_assert.svh
// assertion helpers shared by the stepper modules
// each expects clk and arst_n in the scope where it is used
`ifndef INTEGER_PARTITION_STEPPER_CORE_ASSERT_SVH
`define INTEGER_PARTITION_STEPPER_CORE_ASSERT_SVH

// same-cycle implication
`define IPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IPS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ips_pkg.sv
`timescale 1ns / 1ps

package ips_pkg;

	// width of every result field and of the configured total
	localparam int FIELD_W       = 7;
	localparam int MAX_TOTAL_DEF = 64;
	// at most this many pairs are given per partition
	localparam int MAX_RESULTS   = 10;
	localparam int EMIT_W        = $clog2(MAX_RESULTS + 1);

	// controller to datapath
	typedef struct packed {
		logic restart_load;
		logic rd_last;
		logic take_ones;
		logic pivot;
		logic wr_quot;
		logic wr_rem;
		logic emit_start;
		logic emit_load;
		logic exh_load;
	} ips_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;
		logic last_one;
		logic idx_zero;
		logic pivot_bad;
		logic div_busy;
		logic rem_zero;
		logic out_free;
		logic emit_last;
	} ips_sts_t;

endpackage

FILE: rtl/ips_div.sv
`timescale 1ns / 1ps

module ips_div import ips_pkg::*; #(
	parameter int VW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [VW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [VW-1:0] quotient,
	output logic [VW-1:0] remainder
);

	localparam int SW = $clog2(VW + 1);

	logic [VW-1:0] rem_q;
	logic [VW-1:0] quo_q;
	logic [VW-1:0] dvs_q;
	logic [SW-1:0] step_q;
	logic          busy_q;
	logic [VW:0]   shifted;
	logic          ge;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[VW-1]};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= SW'(VW);
		end else if (busy_q) begin
			step_q <= step_q - SW'(1);
			if (step_q == SW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VW-2:0], ge};
			rem_q <= ge ? VW'(shifted - {1'b0, dvs_q}) : VW'(shifted);
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/ips_dpath.sv
`timescale 1ns / 1ps
`include "integer_partition_stepper_core_assert.svh"

module ips_dpath import ips_pkg::*; #(
	parameter int MAX_TOTAL = MAX_TOTAL_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] total_value,
	input  ips_cmd_t           cmd,
	output ips_sts_t           sts,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] part_value,
	output logic [FIELD_W-1:0] multiplicity,
	output logic               last_pair,
	output logic               exhausted
);

	localparam int DEPTH = MAX_TOTAL + 2;
	localparam int VW    = $clog2(MAX_TOTAL + 1);
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int EW    = 2 * VW;

	// each entry holds {part value, multiplicity}
	logic [EW-1:0]      part_mem_q [DEPTH];
	logic [EW-1:0]      rd_q;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic               wr_en;
	logic [EW-1:0]      wr_data;

	logic [FIELD_W-1:0] total_q;
	logic [CW-1:0]      cnt_q;
	logic               done_q;
	logic [AW-1:0]      idx_q;
	logic [VW-1:0]      sum_q;
	logic [VW-1:0]      low_q;
	logic [EMIT_W-1:0]  k_q;

	logic               out_valid_q;
	logic [FIELD_W-1:0] part_value_q;
	logic [FIELD_W-1:0] multiplicity_q;
	logic               last_pair_q;
	logic               exhausted_q;

	logic [VW-1:0]      rd_val;
	logic [VW-1:0]      rd_cnt;
	logic [VW-1:0]      piv_dec;
	logic [VW-1:0]      t_clamp;
	logic [VW-1:0]      quot;
	logic [VW-1:0]      rem;
	logic               div_busy;
	logic               out_free;

	assign rd_val  = rd_q[EW-1:VW];
	assign rd_cnt  = rd_q[VW-1:0];
	assign piv_dec = rd_cnt - VW'(1);

	always_comb begin
		if (total_q == '0) begin
			t_clamp = VW'(1);
		end else if (32'(total_q) > 32'(MAX_TOTAL)) begin
			t_clamp = VW'(MAX_TOTAL);
		end else begin
			t_clamp = VW'(total_q);
		end
	end

	ips_div #(
		.VW (VW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.pivot),
		.dividend  (VW'(sum_q + rd_val)),
		.divisor   (rd_val - VW'(1)),
		.busy      (div_busy),
		.quotient  (quot),
		.remainder (rem)
	);

	always_comb begin
		if (cmd.rd_last) begin
			rd_addr = AW'(cnt_q - CW'(1));
		end else if (cmd.take_ones) begin
			rd_addr = idx_q - AW'(1);
		end else if (cmd.emit_start) begin
			rd_addr = '0;
		end else if (cmd.emit_load) begin
			rd_addr = AW'(k_q + EMIT_W'(1));
		end else begin
			rd_addr = AW'(k_q);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = {low_q, quot};
		if (cmd.restart_load) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = {t_clamp, VW'(1)};
		end else if (cmd.pivot) begin
			wr_en   = piv_dec != '0;
			wr_data = {rd_val, piv_dec};
		end else if (cmd.wr_quot) begin
			wr_en   = 1'b1;
			wr_data = {low_q, quot};
		end else if (cmd.wr_rem) begin
			wr_en   = 1'b1;
			wr_data = {rem, VW'(1)};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			part_mem_q[wr_addr] <= wr_data;
		end
		rd_q <= part_mem_q[rd_addr];
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= FIELD_W'(1);
			cnt_q       <= CW'(1);
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_q <= total_value;
			end
			if (cmd.restart_load) begin
				cnt_q  <= CW'(1);
				done_q <= 1'b0;
			end
			if (cmd.exh_load) begin
				done_q <= 1'b1;
			end
			if ((cmd.wr_quot && rem == '0) || cmd.wr_rem) begin
				cnt_q <= CW'(idx_q) + CW'(1);
			end
			if (cmd.emit_load || cmd.exh_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_last) begin
			idx_q <= AW'(cnt_q - CW'(1));
			sum_q <= '0;
		end
		if (cmd.take_ones) begin
			idx_q <= idx_q - AW'(1);
			sum_q <= rd_cnt;
		end
		if (cmd.pivot) begin
			low_q <= rd_val - VW'(1);
			if (piv_dec != '0) begin
				idx_q <= idx_q + AW'(1);
			end
		end
		if (cmd.wr_quot && rem != '0) begin
			idx_q <= idx_q + AW'(1);
		end
		if (cmd.emit_start) begin
			k_q <= '0;
		end
		if (cmd.emit_load) begin
			k_q            <= k_q + EMIT_W'(1);
			part_value_q   <= FIELD_W'(rd_val);
			multiplicity_q <= FIELD_W'(rd_cnt);
			last_pair_q    <= sts.emit_last;
			exhausted_q    <= 1'b0;
		end
		if (cmd.exh_load) begin
			part_value_q   <= '0;
			multiplicity_q <= '0;
			last_pair_q    <= 1'b1;
			exhausted_q    <= 1'b1;
		end
	end

	always_comb begin
		sts.done      = done_q;
		sts.last_one  = rd_val == VW'(1);
		sts.idx_zero  = idx_q == '0;
		sts.pivot_bad = rd_val <= VW'(1) || rd_cnt == '0 ||
			(32'(idx_q) + 32'd2 >= 32'(DEPTH));
		sts.div_busy  = div_busy;
		sts.rem_zero  = rem == '0;
		sts.out_free  = out_free;
		sts.emit_last = (32'(k_q) + 32'd1 == 32'(cnt_q)) ||
			(32'(k_q) + 32'd1 == 32'(MAX_RESULTS));
	end

	assign out_valid    = out_valid_q;
	assign part_value   = part_value_q;
	assign multiplicity = multiplicity_q;
	assign last_pair    = last_pair_q;
	assign exhausted    = exhausted_q;

	`IPS_ASSERT_IMP(a_load_when_free, cmd.emit_load || cmd.exh_load, out_free, "result overwritten while stalled")
	`IPS_ASSERT_IMP(a_count_nonzero, 1'b1, cnt_q != '0, "distinct count dropped to zero")
	`IPS_ASSERT_NXT(a_restart_single, cmd.restart_load, cnt_q == CW'(1) && !done_q, "restart did not load one part")

endmodule

FILE: rtl/ips_ctrl.sv
`timescale 1ns / 1ps
`include "integer_partition_stepper_core_assert.svh"

module ips_ctrl import ips_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     restart,
	output logic     in_stall,
	input  ips_sts_t sts,
	output ips_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK_LAST,
		ST_CHK_PIV,
		ST_DIV,
		ST_WR_REM,
		ST_EMIT_RD,
		ST_EMIT,
		ST_EXH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (restart) begin
						cmd.restart_load = 1'b1;
						state_nxt        = ST_EMIT_RD;
					end else if (sts.done) begin
						state_nxt = ST_EXH;
					end else begin
						cmd.rd_last = 1'b1;
						state_nxt   = ST_CHK_LAST;
					end
				end
			end
			ST_CHK_LAST: begin
				// trailing ones fold into the sum, then the part above them is lowered
				if (sts.last_one) begin
					if (sts.idx_zero) begin
						state_nxt = ST_EXH;
					end else begin
						cmd.take_ones = 1'b1;
						state_nxt     = ST_CHK_PIV;
					end
				end else if (sts.pivot_bad) begin
					state_nxt = ST_EXH;
				end else begin
					cmd.pivot = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_CHK_PIV: begin
				if (sts.pivot_bad) begin
					state_nxt = ST_EXH;
				end else begin
					cmd.pivot = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					cmd.wr_quot = 1'b1;
					state_nxt   = sts.rem_zero ? ST_EMIT_RD : ST_WR_REM;
				end
			end
			ST_WR_REM: begin
				cmd.wr_rem = 1'b1;
				state_nxt  = ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				cmd.emit_start = 1'b1;
				state_nxt      = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					if (sts.emit_last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_EXH: begin
				if (sts.out_free) begin
					cmd.exh_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = state_q != ST_IDLE;

	`IPS_ASSERT_NXT(a_accept_starts, state_q == ST_IDLE && in_valid, state_q != ST_IDLE, "accepted request did not start work")
	`IPS_ASSERT_IMP(a_div_quiet_idle, state_q == ST_IDLE, !sts.div_busy, "divider running while idle")
	`IPS_ASSERT_NXT(a_emit_closes, state_q == ST_EMIT && sts.out_free && sts.emit_last, state_q == ST_IDLE, "last pair did not end the partition")

endmodule

FILE: rtl/integer_partition_stepper_core.sv
// integer partition stepper: walks the partitions of total_value in reverse lexicographic
// order, keeping each partition as distinct parts (largest first) with multiplicities in a
// small single-port-write memory. a request with restart high loads the partition {total};
// a request with restart low moves to the next partition. each request returns one result
// per distinct part (at most ten, the last flagged by last_pair), or a single exhausted
// result once the all-ones partition has been passed. one request is worked on at a time:
// a restart writes the entry {total, 1} and reads it back before loading its pair; an
// advance reads the last entry, folds it into the sum if it holds ones, finds the part
// to lower, runs the bit-serial divider that refills the freed sum, writes the quotient
// entry and any remainder entry, then reads the entries back and loads one pair at a
// time into the output register, waiting while out_stall holds it. a new request is taken
// while the last result still waits in that register. total_value is captured on cfg_we
// and used on restart only; a total of 0 acts as 1 and a total above MAX_TOTAL acts as
// MAX_TOTAL. an advance before the first restart is not defined
`timescale 1ns / 1ps

module integer_partition_stepper_core import ips_pkg::*; #(
	parameter int MAX_TOTAL = MAX_TOTAL_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] total_value,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               restart,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] part_value,
	output logic [FIELD_W-1:0] multiplicity,
	output logic               last_pair,
	output logic               exhausted
);

	// command and status between sequencer and datapath
	ips_cmd_t cmd;
	ips_sts_t sts;

	// datapath: part memory, divider, output register
	ips_dpath #(
		.MAX_TOTAL (MAX_TOTAL)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.total_value  (total_value),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.part_value   (part_value),
		.multiplicity (multiplicity),
		.last_pair    (last_pair),
		.exhausted    (exhausted)
	);

	// sequencer: one request from accept to last result load
	ips_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.restart  (restart),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

endmodule
